### design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define WCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal keeps its value in the cycle after the condition holds.
`define WCS_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  `WCS_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

### design/wcs_pkg.sv
// Package for the whitespace-collapsed substring search: types, codes and
// byte helpers. No dependencies.
package wcs_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_END     = 2'd3
  } cmd_e;

  // One word moving from the input register into the update logic.
  typedef struct packed {
    logic       go;
    cmd_e       cmd;
    logic [7:0] ch;
  } step_t;

  // Flags reported by the text matcher.
  typedef struct packed {
    logic seen;
    logic overflow;
  } match_stat_t;

  // One result word.
  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic        pattern_too_long;
    logic        text_too_long;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == SPACE_CHAR);
  endfunction

  // Folds ASCII upper case to lower case; all other bytes pass unchanged.
  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

endpackage

### design/wcs_if.sv
// Valid/ready channel interfaces for the input and result words.
// No dependencies.
interface wcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_byte;

  modport source (output valid, command, char_byte, input ready);
  modport sink (input valid, command, char_byte, output ready);
endinterface

interface wcs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] position;
  logic        pattern_too_long;
  logic        text_too_long;

  modport source (output valid, found, position, pattern_too_long, text_too_long,
                  input ready);
  modport sink (input valid, found, position, pattern_too_long, text_too_long,
                output ready);
endinterface

### design/wcs_pattern.sv
// Pattern store: collapses pattern bytes and keeps them right-aligned, folded.
// Depends on wcs_pkg.
module wcs_pattern import wcs_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_t            step_i,
  output logic [7:0]       pat_o [PATTERN_MAX],
  output logic [LEN_W-1:0] len_o,
  output logic             overflow_o
);

  localparam logic [LEN_W-1:0] LenFull = LEN_W'(PATTERN_MAX);

  logic [7:0]       pat_q [PATTERN_MAX];
  logic [7:0]       pat_a [PATTERN_MAX];
  logic [7:0]       pat_d [PATTERN_MAX];
  logic [LEN_W-1:0] len_q, len_a, len_d;
  logic             ovf_q, ovf_a, ovf_d;
  logic             pend_q, pend_d;
  logic             is_pat, push_sp, push_ch;

  assign is_pat  = step_i.go && (step_i.cmd == CMD_PATTERN);
  assign push_ch = is_pat && !is_space(step_i.ch);
  assign push_sp = push_ch && pend_q;

  // Up to two appends per word: the pending space, then the byte itself.
  always_comb begin
    pat_a = pat_q;
    len_a = len_q;
    ovf_a = ovf_q;
    if (push_sp) begin
      if (len_q == LenFull) begin
        ovf_a = 1'b1;
      end else begin
        for (int i = 0; i < int'(PATTERN_MAX) - 1; i++) pat_a[i] = pat_q[i+1];
        pat_a[PATTERN_MAX-1] = SPACE_CHAR;
        len_a = len_q + 1'b1;
      end
    end
    pat_d = pat_a;
    len_d = len_a;
    ovf_d = ovf_a;
    if (push_ch) begin
      if (len_a == LenFull) begin
        ovf_d = 1'b1;
      end else begin
        for (int i = 0; i < int'(PATTERN_MAX) - 1; i++) pat_d[i] = pat_a[i+1];
        pat_d[PATTERN_MAX-1] = fold(step_i.ch);
        len_d = len_a + 1'b1;
      end
    end
    pend_d = pend_q;
    if (is_pat) begin
      pend_d = is_space(step_i.ch) ? (len_q != '0) : 1'b0;
    end
    if (step_i.go && (step_i.cmd == CMD_BEGIN)) begin
      len_d  = '0;
      ovf_d  = 1'b0;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      pend_q <= pend_d;
    end
  end

  assign pat_o      = pat_q;
  assign len_o      = len_q;
  assign overflow_o = ovf_q;

endmodule

### design/wcs_matcher.sv
// Text window and matcher: collapses text bytes, slides them through a window
// and compares it with the stored pattern. Depends on wcs_pkg.
module wcs_matcher import wcs_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  step_t                  step_i,
  input  logic [7:0]             pat_i [PATTERN_MAX],
  input  logic [LEN_W-1:0]       len_i,
  output match_stat_t            stat_o,
  output logic [COUNT_WIDTH-1:0] offset_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [7:0]             win_q [PATTERN_MAX];
  logic [7:0]             win_a [PATTERN_MAX];
  logic [7:0]             win_d [PATTERN_MAX];
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_a, cnt_d;
  logic [COUNT_WIDTH-1:0] off_q, off_a, off_d;
  logic                   seen_q, seen_a, seen_d;
  logic                   ovf_q, ovf_a, ovf_d;
  logic                   pend_q, pend_d;
  logic                   started_q, started_d;
  logic                   is_txt, push_sp, push_ch;
  logic [PATTERN_MAX-1:0] mask;

  // Window slots that line up with stored pattern bytes.
  always_comb begin
    for (int i = 0; i < int'(PATTERN_MAX); i++) begin
      mask[i] = (i + int'(len_i)) >= int'(PATTERN_MAX);
    end
  end

  function automatic logic window_hit(input logic [7:0] win [PATTERN_MAX],
                                      input logic [7:0] pat [PATTERN_MAX],
                                      input logic [PATTERN_MAX-1:0] msk);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < int'(PATTERN_MAX); i++) begin
      if (msk[i] && (win[i] != pat[i])) hit = 1'b0;
    end
    return hit;
  endfunction

  assign is_txt  = step_i.go && (step_i.cmd == CMD_TEXT);
  assign push_ch = is_txt && !is_space(step_i.ch);
  assign push_sp = push_ch && pend_q;

  // Each push is checked against the counter limit, then compared with the pattern unless a match is already held.
  always_comb begin
    win_a  = win_q;
    cnt_a  = cnt_q;
    off_a  = off_q;
    seen_a = seen_q;
    ovf_a  = ovf_q;
    if (push_sp) begin
      if (cnt_q == CntMax) begin
        ovf_a = 1'b1;
      end else begin
        for (int i = 0; i < int'(PATTERN_MAX) - 1; i++) win_a[i] = win_q[i+1];
        win_a[PATTERN_MAX-1] = SPACE_CHAR;
        cnt_a = cnt_q + 1'b1;
        if (!seen_q && (len_i != '0) && (CMP_W'(cnt_a) >= CMP_W'(len_i)) &&
            window_hit(win_a, pat_i, mask)) begin
          seen_a = 1'b1;
          off_a  = cnt_a - COUNT_WIDTH'(len_i);
        end
      end
    end
    win_d  = win_a;
    cnt_d  = cnt_a;
    off_d  = off_a;
    seen_d = seen_a;
    ovf_d  = ovf_a;
    if (push_ch) begin
      if (cnt_a == CntMax) begin
        ovf_d = 1'b1;
      end else begin
        for (int i = 0; i < int'(PATTERN_MAX) - 1; i++) win_d[i] = win_a[i+1];
        win_d[PATTERN_MAX-1] = fold(step_i.ch);
        cnt_d = cnt_a + 1'b1;
        if (!seen_a && (len_i != '0) && (CMP_W'(cnt_d) >= CMP_W'(len_i)) &&
            window_hit(win_d, pat_i, mask)) begin
          seen_d = 1'b1;
          off_d  = cnt_d - COUNT_WIDTH'(len_i);
        end
      end
    end
    pend_d    = pend_q;
    started_d = started_q;
    if (is_txt) begin
      if (is_space(step_i.ch)) begin
        pend_d = started_q;
      end else begin
        pend_d    = 1'b0;
        started_d = 1'b1;
      end
    end
    if (step_i.go && (step_i.cmd == CMD_BEGIN)) begin
      cnt_d     = '0;
      off_d     = '0;
      seen_d    = 1'b0;
      ovf_d     = 1'b0;
      pend_d    = 1'b0;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      off_q     <= '0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
      pend_q    <= 1'b0;
      started_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      off_q     <= off_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
      pend_q    <= pend_d;
      started_q <= started_d;
    end
  end

  assign stat_o   = '{seen: seen_q, overflow: ovf_q};
  assign offset_o = off_q;

endmodule

### design/whitespace_collapsed_substring_search.sv
// Top level of the whitespace-collapsed, case-insensitive substring search.
// Depends on wcs_pkg, wcs_if, wcs_pattern and wcs_matcher.
//
// The block takes one word per clock cycle while no end command is held back:
// a begin command, the pattern bytes, the text bytes and an end command. Each
// word first lands in an input register and is applied when it leaves that
// register by a single update stage that collapses whitespace and handles up to
// two collapsed bytes (a pending space and the byte itself) at once, using two
// parallel compares of the whole PATTERN_MAX-byte text window against the
// right-aligned, case-folded pattern. Only the end command produces a result
// word; it is loaded into the output register when the end command leaves the
// input register, and it stays there until taken. While a result waits, pattern
// and text words keep flowing; only a second end command waits in the input
// register until the output register is free.
// Results report whether the collapsed pattern occurs in the collapsed text,
// the offset of the first match (its low 16 bits), and whether
// the pattern overflowed its PATTERN_MAX-byte store or the text overflowed the
// COUNT_WIDTH-bit counter. An empty pattern always matches at offset 0.
module whitespace_collapsed_substring_search import wcs_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  wcs_in_if.sink    in_i,
  wcs_out_if.source out_o
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  // Input register.
  logic       in_valid_q;
  cmd_e       cmd_q;
  logic [7:0] ch_q;
  logic       advance;
  step_t      step;

  // Output register.
  logic out_valid_q;
  res_t res_q, res_d;

  logic [7:0]             pat [PATTERN_MAX];
  logic [LEN_W-1:0]       pat_len;
  logic                   pat_ovf;
  match_stat_t            mstat;
  logic [COUNT_WIDTH-1:0] moff;
  logic [31:0]            moff_ext;

  // A word leaves the input register unless it is an end command that would
  // overwrite a result that has not been taken yet.
  assign advance    = in_valid_q && ((cmd_q != CMD_END) || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign step       = '{go: advance, cmd: cmd_q, ch: ch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= cmd_e'(in_i.command);
      ch_q  <= in_i.char_byte;
    end
  end

  wcs_pattern #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .pat_o      (pat),
    .len_o      (pat_len),
    .overflow_o (pat_ovf)
  );

  wcs_matcher #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_WIDTH (COUNT_WIDTH),
    .LEN_W       (LEN_W)
  ) u_matcher (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pat_i    (pat),
    .len_i    (pat_len),
    .stat_o   (mstat),
    .offset_o (moff)
  );

  // The reported offset is the low 16 bits of the match offset.
  assign moff_ext = 32'(moff);

  always_comb begin
    res_d.pattern_too_long = pat_ovf;
    res_d.text_too_long    = mstat.overflow;
    if (pat_len == '0) begin
      res_d.found    = 1'b1;
      res_d.position = '0;
    end else begin
      res_d.found    = mstat.seen;
      res_d.position = mstat.seen ? moff_ext[15:0] : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && (cmd_q == CMD_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (cmd_q == CMD_END)) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.found            = res_q.found;
  assign out_o.position         = res_q.position;
  assign out_o.pattern_too_long = res_q.pattern_too_long;
  assign out_o.text_too_long    = res_q.text_too_long;

endmodule

### design/wcs_checker.sv
// Port-level checker for the substring search top level, with its bind.
// Depends on wcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcs_checker import wcs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_command_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_found_i,
  input logic [15:0] out_position_i
);

  logic in_end;
  logic out_stall;
  logic miss_pos;
  assign in_end    = in_valid_i && in_ready_i && (in_command_i == CMD_END);
  assign out_stall = out_valid_i && !out_ready_i;
  assign miss_pos  = out_valid_i && !out_found_i && (out_position_i != 16'd0);

  `WCS_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i, "result word dropped")
  `WCS_ASSERT_HOLD(a_pos_stable, clk_i, rst_ni, out_stall, out_position_i, "position moved")
  `WCS_ASSERT(a_pos_found, clk_i, rst_ni, !miss_pos, "nonzero position without a match")
  `WCS_ASSERT(a_rise_end, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_end, 2), "stray result")

endmodule

bind whitespace_collapsed_substring_search wcs_checker u_wcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_found_i    (out_o.found),
  .out_position_i (out_o.position)
);

### tb/tb_whitespace_collapsed_substring_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the whitespace-collapsed substring search.
// Depends on wcs_pkg, wcs_if and whitespace_collapsed_substring_search.
module tb_whitespace_collapsed_substring_search;
  import wcs_pkg::*;

  localparam int unsigned PAT_MAX     = 64;
  localparam int unsigned CNT_WIDTH   = 16;
  localparam int unsigned CNT_MAX     = (1 << CNT_WIDTH) - 1;
  localparam int          CLK_PERIOD  = 20;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          MIX_WORDS   = 700;
  localparam int          CALM_WORDS  = 200;

  localparam logic [7:0] LETTERS [4] = '{8'h61, 8'h41, 8'h62, 8'h42};
  localparam logic [7:0] BLANKS  [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, SPACE_CHAR};

  // One row of the directed table. Only end commands carry a hand-written
  // result, and only where it is obvious; the rest goes through the predictor.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RES    = '0;
  localparam res_t EMPTY_HIT = '{found: 1'b1, position: 16'd0,
                                 pattern_too_long: 1'b0, text_too_long: 1'b0};

  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // Straight out of reset the pattern is empty, so it matches at zero.
    '{CMD_END,     8'h00, 1'b1, EMPTY_HIT},
    '{CMD_BEGIN,   8'hFF, 1'b0, NO_RES},
    // Pattern "A b": a leading blank, a run of two blanks inside and a
    // trailing blank, all of which collapse away or into one space.
    '{CMD_PATTERN, 8'h09, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h41, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h0D, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h20, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h62, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h0A, 1'b0, NO_RES},
    // Text with byte extremes, then "a B" after a blank: match at offset 3.
    '{CMD_TEXT,    8'h0B, 1'b0, NO_RES},
    '{CMD_TEXT,    8'hFF, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h00, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h0C, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h61, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h20, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h42, 1'b0, NO_RES},
    '{CMD_END,     8'h00, 1'b0, NO_RES},
    '{CMD_END,     8'h55, 1'b0, NO_RES},
    // The pattern grows after text has arrived; the earlier match is kept.
    '{CMD_PATTERN, 8'h5A, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h7A, 1'b0, NO_RES},
    '{CMD_END,     8'hAA, 1'b0, NO_RES},
    // Only A-Z fold: '[' and '{' differ by the case bit but must not match.
    '{CMD_BEGIN,   8'h00, 1'b0, NO_RES},
    '{CMD_PATTERN, 8'h5B, 1'b0, NO_RES},
    '{CMD_TEXT,    8'h7B, 1'b0, NO_RES},
    '{CMD_END,     8'h00, 1'b0, NO_RES},
    '{CMD_BEGIN,   8'h3C, 1'b0, NO_RES}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wcs_in_if  in_ch ();
  wcs_out_if out_ch ();

  whitespace_collapsed_substring_search #(
    .PATTERN_MAX(PAT_MAX),
    .COUNT_WIDTH(CNT_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor state: the collapsed pattern, the sliding window over the
  // collapsed text and the flags that the end command reports.
  // ---------------------------------------------------------------------
  logic [7:0]  pat_mem [PAT_MAX];
  int unsigned pat_len;
  bit          pat_gap;
  logic [7:0]  win [PAT_MAX];
  int unsigned txt_cnt;
  bit          txt_gap;
  bit          txt_live;
  bit          hit;
  logic [15:0] hit_at;
  bit          pat_ovf;
  bit          txt_ovf;

  res_t pending_reports [$];
  bit   pinned;
  res_t pinned_res;

  int  words_sent = 0;
  int  miss_count = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  bit  calm_tail = 1'b0;
  bit  hold_req = 1'b0;

  function automatic bit is_blank(logic [7:0] b);
    return b inside {[8'd9:8'd13], SPACE_CHAR};
  endfunction

  function automatic logic [7:0] lower(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  function void wipe_search();
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    pat_len  = 0;
    pat_gap  = 1'b0;
    txt_cnt  = 0;
    txt_gap  = 1'b0;
    txt_live = 1'b0;
    hit      = 1'b0;
    hit_at   = '0;
    pat_ovf  = 1'b0;
    txt_ovf  = 1'b0;
  endfunction

  function void stash_pattern(logic [7:0] b);
    if (pat_len >= PAT_MAX) begin
      pat_ovf = 1'b1;
    end else begin
      pat_mem[pat_len] = b;
      pat_len++;
    end
  endfunction

  // Shifts one collapsed text byte into the window and compares the newest
  // pat_len bytes against the pattern, unless a match is already held.
  function void slide_text(logic [7:0] b);
    bit same;
    if (txt_cnt >= CNT_MAX) begin
      txt_ovf = 1'b1;
      return;
    end
    for (int i = 0; i < PAT_MAX - 1; i++) win[i] = win[i + 1];
    win[PAT_MAX - 1] = b;
    txt_cnt++;
    if (hit || pat_len == 0 || txt_cnt < pat_len) return;
    same = 1'b1;
    for (int j = 0; j < pat_len; j++) begin
      if (lower(win[PAT_MAX - pat_len + j]) != lower(pat_mem[j])) same = 1'b0;
    end
    if (same) begin
      hit    = 1'b1;
      hit_at = 16'(txt_cnt - pat_len);
    end
  endfunction

  // Applies one accepted word; an end command queues the report it causes.
  function void collapse_and_match(cmd_e c, logic [7:0] b);
    res_t r;
    case (c)
      CMD_BEGIN: begin
        wipe_search();
      end
      CMD_PATTERN: begin
        if (is_blank(b)) begin
          pat_gap = (pat_len != 0);
        end else begin
          if (pat_gap) begin
            stash_pattern(SPACE_CHAR);
            pat_gap = 1'b0;
          end
          stash_pattern(b);
        end
      end
      CMD_TEXT: begin
        if (is_blank(b)) begin
          txt_gap = txt_live;
        end else begin
          if (txt_gap) begin
            slide_text(SPACE_CHAR);
            txt_gap = 1'b0;
          end
          slide_text(b);
          txt_live = 1'b1;
        end
      end
      default: begin
        r.found            = (pat_len == 0) || hit;
        r.position         = (pat_len != 0 && hit) ? hit_at : 16'd0;
        r.pattern_too_long = pat_ovf;
        r.text_too_long    = txt_ovf;
        if (pinned) r = pinned_res;
        pending_reports.push_back(r);
      end
    endcase
    pinned = 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Byte sources for the random part. A small alphabet with both cases
  // makes matches common; the odd full-range byte keeps every bit moving.
  // ---------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_blank();
    return BLANKS[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return pick_blank();
    if (r < 85) return LETTERS[$urandom_range(0, 3)];
    return any_byte();
  endfunction

  // Flips the case of a letter half of the time; other bytes pass through.
  function automatic logic [7:0] twist_case(logic [7:0] b);
    if (lower(b) >= 8'h61 && lower(b) <= 8'h7A && $urandom_range(0, 1) == 1)
      return b ^ 8'h20;
    return b;
  endfunction

  function automatic int pick_pat_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 0;
    if (r < 16) return $urandom_range(1, 4);
    if (r < 19) return $urandom_range(5, 12);
    // Long enough to run past the pattern store most of the time.
    return $urandom_range(60, 90);
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Inputs change on the falling edge; a word counts as accepted
  // at the rising edge where valid and ready are both high, and only then
  // does the predictor see it.
  // ---------------------------------------------------------------------
  task automatic offer_word(cmd_e c, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.char_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    collapse_and_match(c, b);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every queued report has come back.
  task automatic await_reports();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  // One search with random content. Copies of the raw pattern are planted in
  // the text with blank runs stretched and letter case flipped, so that the
  // collapse and fold have to line up for the match to be found. Now and
  // then the begin is skipped, a pattern byte lands among the text, or an
  // end arrives early, which makes for broken sequences.
  task automatic random_search(int pat_n, int txt_n);
    logic [7:0] raw_pat [$];
    logic [7:0] b;
    int k;
    if ($urandom_range(0, 7) != 0) offer_word(CMD_BEGIN, any_byte());
    repeat (pat_n) begin
      b = pick_byte();
      raw_pat.push_back(b);
      offer_word(CMD_PATTERN, b);
    end
    k = 0;
    while (k < txt_n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          foreach (raw_pat[i]) begin
            if (is_blank(raw_pat[i]))
              repeat ($urandom_range(1, 3)) offer_word(CMD_TEXT, pick_blank());
            else
              offer_word(CMD_TEXT, twist_case(raw_pat[i]));
          end
          k += raw_pat.size() + 1;
        end
        3: offer_word(CMD_PATTERN, pick_byte());
        4: offer_word(CMD_END, any_byte());
        default: begin
          offer_word(CMD_TEXT, pick_byte());
          k++;
        end
      endcase
    end
    offer_word(CMD_END, any_byte());
    if ($urandom_range(0, 3) == 0) offer_word(CMD_END, any_byte());
  endtask

  // A handful of words with random commands and bytes.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) offer_word(cmd_e'($urandom_range(0, 3)), any_byte());
  endtask

  task automatic mixed_traffic(int goal);
    int pat_n;
    while (words_sent < goal) begin
      // The last part of the run stays calm; before that idling comes and goes.
      if (!calm_tail) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 19) == 0) begin
        noise_burst();
      end else begin
        pat_n = pick_pat_len();
        random_search(pat_n, (pat_n > 40) ? $urandom_range(60, 140) : $urandom_range(0, 30));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver. Ready changes on the falling edge: random stalls while gaps
  // are on, and one long hold-off when the sender asks for it, so that the
  // output register stays full and a second end command backs up the input.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  function automatic string describe(res_t r);
    return $sformatf("found=%0d position=%0d pattern_too_long=%0d text_too_long=%0d",
                     r.found, r.position, r.pattern_too_long, r.text_too_long);
  endfunction

  function void note_miss(string what, res_t want, res_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("%0t mismatch, %s: expected %s, got %s", $realtime, what,
               describe(want), describe(got));
  endfunction

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk_i) begin : report_check
    res_t got;
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.found, out_ch.position, out_ch.pattern_too_long, out_ch.text_too_long};
      if (pending_reports.size() == 0) begin
        note_miss("result with nothing expected", NO_RES, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.pattern_too_long !== want.pattern_too_long ||
            got.text_too_long !== want.text_too_long)
          note_miss("wrong field", want, got);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Run order: directed table, mixed random traffic with idling, a long
  // receiver hold-off followed by a full drain, then a calm last part.
  // ---------------------------------------------------------------------
  initial begin : run_order
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_BEGIN;
    in_ch.char_byte = 8'h00;
    pinned          = 1'b0;
    pinned_res      = NO_RES;
    wipe_search();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      pinned     = DIRECTED_ROWS[i].typed;
      pinned_res = DIRECTED_ROWS[i].want;
      offer_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ch);
    end

    // One guaranteed pass over the pattern store limit.
    random_search(90, 120);
    mixed_traffic(MIX_WORDS);

    // Receiver holds off while several end commands arrive, then the
    // sender pauses until everything has come back.
    hold_req = 1'b1;
    random_search(2, 12);
    offer_word(CMD_TEXT, 8'h61);
    offer_word(CMD_END, 8'h00);
    offer_word(CMD_END, 8'h01);
    offer_word(CMD_TEXT, 8'h42);
    offer_word(CMD_END, 8'h02);
    await_reports();

    calm_tail = 1'b1;
    gaps_on   = 1'b0;
    mixed_traffic(words_sent + CALM_WORDS);

    await_reports();
    repeat (10) @(negedge clk_i);
    if (miss_count == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/wcs_pkg.sv
design/wcs_if.sv
design/wcs_pattern.sv
design/wcs_matcher.sv
design/whitespace_collapsed_substring_search.sv
design/wcs_checker.sv
tb/tb_whitespace_collapsed_substring_search.sv
